// File: sv/lbc_pkg.sv
// shared constants, types and helpers of the lru block cache
`timescale 1ns / 1ps
package lbc_pkg;

   // geometry
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int WORD_BITS  = 64;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int LINE_BITS  = KEY_BITS + WORD_BITS;
   localparam int TOTAL_BITS = 32;

   // register port
   localparam int LIMIT_BITS    = 5;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);
   localparam logic REG_MAX_ENTRIES = 1'b0;

   // item actions
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [IDX_BITS-1:0] rank_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // item being worked on
   typedef struct packed {
      logic                 action;
      logic [KEY_BITS-1:0]  key;
      logic [WORD_BITS-1:0] word;
      logic                 evict_due;
      rank_type             oldest_rank;
   } ctx_type;

   // what the scan has found so far
   typedef struct packed {
      logic                 found;
      idx_type              found_idx;
      rank_type             found_rank;
      logic [WORD_BITS-1:0] found_word;
      logic                 ev;
      idx_type              ev_idx;
      logic [KEY_BITS-1:0]  ev_block;
      logic                 slot_ok;
      idx_type              slot_idx;
   } scan_type;

   // result beat
   typedef struct packed {
      logic                  hit;
      logic [WORD_BITS-1:0]  read_data;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_block;
      logic                  stored;
      logic [TOTAL_BITS-1:0] hit_count;
      logic [TOTAL_BITS-1:0] miss_count;
   } rsp_type;

   // saturating increment of a statistics counter
   function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
      return (&v) ? v : v + TOTAL_BITS'(1);
   endfunction

   // clamp the programmed limit into 1 .. ENTRIES
   function automatic cnt_type limit_of(input logic [LIMIT_BITS-1:0] max_entries);
      int unsigned m;
      m = 32'(max_entries);
      if (m == 0) begin
         m = 1;
      end
      if (m > ENTRIES) begin
         m = ENTRIES;
      end
      return CNT_BITS'(m);
   endfunction

endpackage

// File: sv/lbc_if.sv
// request and response channel interfaces of the lru block cache
`timescale 1ns / 1ps
interface lbc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [lbc_pkg::KEY_BITS-1:0]  block_number;
   logic [lbc_pkg::WORD_BITS-1:0] fill_data;

   modport source (output valid, action, block_number, fill_data, input ready);
   modport sink (input valid, action, block_number, fill_data, output ready);
endinterface

interface lbc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [lbc_pkg::WORD_BITS-1:0]  read_data;
   logic                           evicted;
   logic [lbc_pkg::KEY_BITS-1:0]   evicted_block;
   logic                           stored;
   logic [lbc_pkg::TOTAL_BITS-1:0] hit_count;
   logic [lbc_pkg::TOTAL_BITS-1:0] miss_count;

   modport source (output valid, hit, read_data, evicted, evicted_block, stored,
                   hit_count, miss_count, input ready);
   modport sink (input valid, hit, read_data, evicted, evicted_block, stored,
                 hit_count, miss_count, output ready);
endinterface

// File: sv/lru_block_cache_core.sv
// Each item runs a one-entry-a-cycle read scan of the line ram, then a drain state, a commit
// state that waits while a result is still held, and an idle state that takes the next request beat.
// The result register lets the next request beat in while a result still waits.
// Reset (synchronous): valid bits, ranks and hit/miss totals clear,
// max_entries returns to 16; the line ram is not cleared.
`timescale 1ns / 1ps
module lru_block_cache_core (
   input  logic                              clock,
   input  logic                              reset,
   lbc_req_if.sink                           req_chan,
   lbc_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   lbc_pkg::cnt_type                limit;
   logic                            ram_wr_en;
   lbc_pkg::idx_type                ram_wr_addr;
   logic [lbc_pkg::LINE_BITS-1:0]   ram_wr_data;
   logic                            ram_rd_en;
   lbc_pkg::idx_type                ram_rd_addr;
   logic [lbc_pkg::LINE_BITS-1:0]   ram_rd_data;

   // limit register
   lbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limit       (limit)
   );

   // line store: block number over data word
   lbc_ram #(
      .WIDTH (lbc_pkg::LINE_BITS),
      .DEPTH (lbc_pkg::ENTRIES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer and recency
   lbc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule

// File: sv/lbc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lbc_csr.sv
// register port holding the max_entries limit
`timescale 1ns / 1ps
module lbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output lbc_pkg::cnt_type                    limit
);

   logic [lbc_pkg::LIMIT_BITS-1:0] max_entries_ff;
   logic [lbc_pkg::LIMIT_BITS-1:0] max_entries_in;
   logic                           wr_hit;

   // write decode, word address in paddr[2]
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == lbc_pkg::REG_MAX_ENTRIES);

   always_comb begin
      max_entries_in = max_entries_ff;
      if (wr_hit) begin
         max_entries_in = csr_pwdata[lbc_pkg::LIMIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= lbc_pkg::LIMIT_RESET;
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lbc_pkg::REG_MAX_ENTRIES) begin
         csr_prdata = lbc_pkg::CSR_DATA_BITS'(max_entries_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign limit      = lbc_pkg::limit_of(max_entries_ff);

endmodule

// File: sv/lbc_engine.sv
// scan sequencer, recency ranks and result register of the lru block cache
`timescale 1ns / 1ps
module lbc_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  lbc_pkg::cnt_type                limit,
   lbc_req_if.sink                         req_chan,
   lbc_rsp_if.source                       rsp_chan,
   output logic                            ram_wr_en,
   output lbc_pkg::idx_type                ram_wr_addr,
   output logic [lbc_pkg::LINE_BITS-1:0]   ram_wr_data,
   output logic                            ram_rd_en,
   output lbc_pkg::idx_type                ram_rd_addr,
   input  logic [lbc_pkg::LINE_BITS-1:0]   ram_rd_data
);

   localparam int N = lbc_pkg::ENTRIES;

   lbc_pkg::state_type state_ff, state_in;
   lbc_pkg::idx_type   scan_addr_ff, scan_addr_in;
   logic               pipe_vld_ff, pipe_vld_in;
   lbc_pkg::idx_type   pipe_idx_ff, pipe_idx_in;
   lbc_pkg::ctx_type   ctx_ff, ctx_in;
   lbc_pkg::scan_type  scan_ff, scan_in;
   logic [N-1:0]       valid_ff, valid_in;
   lbc_pkg::rank_type  rank_ff [N];
   lbc_pkg::rank_type  rank_in [N];
   lbc_pkg::cnt_type   count_ff, count_in;
   logic [lbc_pkg::TOTAL_BITS-1:0] hit_total_ff, hit_total_in;
   logic [lbc_pkg::TOTAL_BITS-1:0] miss_total_ff, miss_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lbc_pkg::rsp_type   rsp_ff, rsp_in;

   logic accept;
   logic last_addr;
   logic commit;

   logic                          e_valid;
   lbc_pkg::rank_type             e_rank;
   logic [lbc_pkg::KEY_BITS-1:0]  e_key;
   logic [lbc_pkg::WORD_BITS-1:0] e_word;
   logic                          is_oldest;
   logic                          is_match;
   logic                          is_free;

   logic [N-1:0] after_evict;
   logic         do_store;

   // handshake
   assign accept    = req_chan.valid && req_chan.ready;
   assign last_addr = (scan_addr_ff == lbc_pkg::IDX_BITS'(N - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lbc_pkg::ST_SCAN;
            end
         end
         lbc_pkg::ST_SCAN: begin
            if (last_addr) begin
               state_in = lbc_pkg::ST_DRAIN;
            end
         end
         lbc_pkg::ST_DRAIN: begin
            state_in = lbc_pkg::ST_FINISH;
         end
         lbc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = lbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbc_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         lbc_pkg::ST_SCAN: begin
            ram_rd_en = 1'b1;
         end
         lbc_pkg::ST_DRAIN: begin
            ram_rd_en = 1'b0;
         end
         lbc_pkg::ST_FINISH: begin
            commit = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            commit = 1'b0;
         end
      endcase
   end

   // scan address and read pipeline
   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (accept) begin
         scan_addr_in = '0;
      end else if (state_ff == lbc_pkg::ST_SCAN) begin
         scan_addr_in = scan_addr_ff + lbc_pkg::IDX_BITS'(1);
      end
      pipe_vld_in = (state_ff == lbc_pkg::ST_SCAN);
      pipe_idx_in = scan_addr_ff;
   end

   assign ram_rd_addr = scan_addr_ff;

   // item context captured at accept
   always_comb begin
      ctx_in = ctx_ff;
      if (accept) begin
         ctx_in.action      = req_chan.action;
         ctx_in.key         = req_chan.block_number;
         ctx_in.word        = req_chan.fill_data;
         ctx_in.evict_due   = (req_chan.action == lbc_pkg::ACT_INSERT) && (count_ff >= limit);
         ctx_in.oldest_rank = lbc_pkg::IDX_BITS'(count_ff - lbc_pkg::CNT_BITS'(1));
      end
   end

   // classify the entry coming back from the ram
   always_comb begin
      e_valid   = valid_ff[pipe_idx_ff];
      e_rank    = rank_ff[pipe_idx_ff];
      e_key     = ram_rd_data[lbc_pkg::LINE_BITS-1:lbc_pkg::WORD_BITS];
      e_word    = ram_rd_data[lbc_pkg::WORD_BITS-1:0];
      is_oldest = ctx_ff.evict_due && e_valid && (e_rank == ctx_ff.oldest_rank);
      is_match  = e_valid && (e_key == ctx_ff.key) && !is_oldest;
      is_free   = !e_valid || is_oldest;
   end

   // collect match, victim and first free slot
   always_comb begin
      scan_in = scan_ff;
      if (accept) begin
         scan_in = '0;
      end else if (pipe_vld_ff) begin
         if (is_match && !scan_ff.found) begin
            scan_in.found      = 1'b1;
            scan_in.found_idx  = pipe_idx_ff;
            scan_in.found_rank = e_rank;
            scan_in.found_word = e_word;
         end
         if (is_oldest) begin
            scan_in.ev       = 1'b1;
            scan_in.ev_idx   = pipe_idx_ff;
            scan_in.ev_block = e_key;
         end
         if (is_free && !scan_ff.slot_ok) begin
            scan_in.slot_ok  = 1'b1;
            scan_in.slot_idx = pipe_idx_ff;
         end
      end
   end

   // commit: recency, valid bits, totals, line write, result beat
   always_comb begin
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      count_in      = count_ff;
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      rsp_in        = rsp_ff;
      after_evict   = valid_ff;
      do_store      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = scan_ff.slot_idx;
      ram_wr_data   = {ctx_ff.key, ctx_ff.word};

      if (scan_ff.ev) begin
         after_evict[scan_ff.ev_idx] = 1'b0;
      end

      if (commit) begin
         if (ctx_ff.action == lbc_pkg::ACT_LOOKUP) begin
            if (scan_ff.found) begin
               // promote the hit entry, entries newer than it age by one
               for (int i = 0; i < N; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < scan_ff.found_rank)) begin
                     rank_in[i] = rank_ff[i] + lbc_pkg::IDX_BITS'(1);
                  end
               end
               rank_in[scan_ff.found_idx] = '0;
               hit_total_in = lbc_pkg::sat_inc(hit_total_ff);
            end else begin
               miss_total_in = lbc_pkg::sat_inc(miss_total_ff);
            end
            rsp_in.hit           = scan_ff.found;
            rsp_in.read_data     = scan_ff.found ? scan_ff.found_word : '0;
            rsp_in.evicted       = 1'b0;
            rsp_in.evicted_block = '0;
            rsp_in.stored        = 1'b0;
         end else begin
            do_store = !scan_ff.found && scan_ff.slot_ok;
            valid_in = after_evict;
            if (do_store) begin
               // every survivor ages, new line is most recent
               for (int i = 0; i < N; i++) begin
                  if (after_evict[i]) begin
                     rank_in[i] = rank_ff[i] + lbc_pkg::IDX_BITS'(1);
                  end
               end
               rank_in[scan_ff.slot_idx]  = '0;
               valid_in[scan_ff.slot_idx] = 1'b1;
               ram_wr_en                  = 1'b1;
            end
            if (scan_ff.ev) begin
               rank_in[scan_ff.ev_idx] = '0;
               if (do_store && (scan_ff.ev_idx == scan_ff.slot_idx)) begin
                  rank_in[scan_ff.ev_idx] = '0;
               end
            end
            count_in = count_ff - lbc_pkg::CNT_BITS'(scan_ff.ev)
                       + lbc_pkg::CNT_BITS'(do_store);
            rsp_in.hit           = 1'b0;
            rsp_in.read_data     = '0;
            rsp_in.evicted       = scan_ff.ev;
            rsp_in.evicted_block = scan_ff.ev ? scan_ff.ev_block : '0;
            rsp_in.stored        = do_store;
         end
         rsp_in.hit_count  = hit_total_in;
         rsp_in.miss_count = miss_total_in;
      end
   end

   // result register
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_chan.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbc_pkg::ST_IDLE;
         pipe_vld_ff   <= 1'b0;
         scan_ff       <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pipe_vld_ff   <= pipe_vld_in;
         scan_ff       <= scan_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         rank_ff       <= rank_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      pipe_idx_ff  <= pipe_idx_in;
      ctx_ff       <= ctx_in;
      rsp_ff       <= rsp_in;
   end

   // response channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_ff.hit;
   assign rsp_chan.read_data     = rsp_ff.read_data;
   assign rsp_chan.evicted       = rsp_ff.evicted;
   assign rsp_chan.evicted_block = rsp_ff.evicted_block;
   assign rsp_chan.stored        = rsp_ff.stored;
   assign rsp_chan.hit_count     = rsp_ff.hit_count;
   assign rsp_chan.miss_count    = rsp_ff.miss_count;

endmodule

// File: tb/lbc_cache_checker.sv
// checker for the lru block cache: predicts each result beat and compares it field by field
`timescale 1ns / 1ps
module lbc_cache_checker
   import lbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   lbc_req_if                       req_mon,
   lbc_rsp_if                       rsp_mon,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       results_pending
);

   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR = CSR_ADDR_BITS'(4 * int'(REG_MAX_ENTRIES));
   localparam int PRINT_CAP = 40;

   // shadow of the cache contents and statistics
   logic                   line_valid [ENTRIES];
   logic [KEY_BITS-1:0]    line_key   [ENTRIES];
   logic [WORD_BITS-1:0]   line_word  [ENTRIES];
   rank_type               line_rank  [ENTRIES];
   logic [TOTAL_BITS-1:0]  hit_total;
   logic [TOTAL_BITS-1:0]  miss_total;
   logic [LIMIT_BITS-1:0]  limit_reg;

   rsp_type                answers_q [$];
   int                     mismatches = 0;
   int                     beats_seen = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t: result beat %0d, %s mismatch: got %h want %h",
                  $time, beats_seen, what, got, want);
      end
      mismatches++;
   endtask

   // index of the valid line holding key, or -1
   function automatic int line_of(input logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
         if (line_valid[i] && line_key[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // applies one lookup or insert to the shadow cache and returns its result beat
   function automatic rsp_type cache_access(input logic act, input logic [KEY_BITS-1:0] key,
                                            input logic [WORD_BITS-1:0] word);
      rsp_type  r;
      int       at;
      int       oldest;
      int       slot;
      int       filled;
      int       lim;
      rank_type old_rank;
      r = '0;
      if (act == ACT_LOOKUP) begin
         at = line_of(key);
         if (at >= 0) begin
            r.hit       = 1'b1;
            r.read_data = line_word[at];
            // lines more recent than the hit one age by one
            old_rank = line_rank[at];
            for (int i = 0; i < ENTRIES; i++) begin
               if (line_valid[i] && line_rank[i] < old_rank) begin
                  line_rank[i] = line_rank[i] + 1'b1;
               end
            end
            line_rank[at] = '0;
            if (!(&hit_total)) begin
               hit_total = hit_total + 1'b1;
            end
         end else if (!(&miss_total)) begin
            miss_total = miss_total + 1'b1;
         end
      end else begin
         // zero acts as one, anything past the array acts as full size
         lim = int'(limit_reg);
         if (lim < 1) begin
            lim = 1;
         end
         if (lim > ENTRIES) begin
            lim = ENTRIES;
         end
         filled = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            filled += int'(line_valid[i]);
         end
         // drop the least recent line once the limit is reached
         if (filled >= lim) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (line_valid[i] && (oldest < 0 || line_rank[i] > line_rank[oldest])) begin
                  oldest = i;
               end
            end
            if (oldest >= 0) begin
               r.evicted         = 1'b1;
               r.evicted_block   = line_key[oldest];
               line_valid[oldest] = 1'b0;
               line_rank[oldest]  = '0;
            end
         end
         // a block still present stays as it is
         if (line_of(key) < 0) begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !line_valid[i]) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (line_valid[i]) begin
                     line_rank[i] = line_rank[i] + 1'b1;
                  end
               end
               line_valid[slot] = 1'b1;
               line_key[slot]   = key;
               line_word[slot]  = word;
               line_rank[slot]  = '0;
               r.stored         = 1'b1;
            end
         end
      end
      r.hit_count  = hit_total;
      r.miss_count = miss_total;
      return r;
   endfunction

   // watch the request, result and register ports on every edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = '0;
         end
         hit_total  = '0;
         miss_total = '0;
         limit_reg  = LIMIT_RESET;
         answers_q.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_q.size() == 0) begin
               report_mismatch("unexpected beat, valid", 64'(rsp_mon.valid), 64'(1'b0));
            end else begin
               want = answers_q.pop_front();
               if (rsp_mon.hit !== want.hit) begin
                  report_mismatch("hit", 64'(rsp_mon.hit), 64'(want.hit));
               end
               if (rsp_mon.read_data !== want.read_data) begin
                  report_mismatch("read_data", rsp_mon.read_data, want.read_data);
               end
               if (rsp_mon.evicted !== want.evicted) begin
                  report_mismatch("evicted", 64'(rsp_mon.evicted), 64'(want.evicted));
               end
               if (rsp_mon.evicted_block !== want.evicted_block) begin
                  report_mismatch("evicted_block", 64'(rsp_mon.evicted_block),
                                  64'(want.evicted_block));
               end
               if (rsp_mon.stored !== want.stored) begin
                  report_mismatch("stored", 64'(rsp_mon.stored), 64'(want.stored));
               end
               if (rsp_mon.hit_count !== want.hit_count) begin
                  report_mismatch("hit_count", 64'(rsp_mon.hit_count), 64'(want.hit_count));
               end
               if (rsp_mon.miss_count !== want.miss_count) begin
                  report_mismatch("miss_count", 64'(rsp_mon.miss_count),
                                  64'(want.miss_count));
               end
            end
            beats_seen++;
         end
         // register access phase at the limit address; other addresses are not tracked
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LIMIT_ADDR) begin
            if (csr_pwrite) begin
               limit_reg = csr_pwdata[LIMIT_BITS-1:0];
            end else if (csr_prdata !== CSR_DATA_BITS'(limit_reg)) begin
               report_mismatch("max_entries readback", 64'(csr_prdata), 64'(limit_reg));
            end
         end
         // request beat
         if (req_mon.valid && req_mon.ready) begin
            answers_q.push_back(cache_access(req_mon.action, req_mon.block_number,
                                             req_mon.fill_data));
         end
      end
      results_pending <= answers_q.size();
   end

endmodule

// File: tb/lru_block_cache_core_tb.sv
// top of the lru block cache bench: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps
module lru_block_cache_core_tb;
   import lbc_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR  = CSR_ADDR_BITS'(4 * int'(REG_MAX_ENTRIES));
   // index one, past the end of the register list
   localparam logic [CSR_ADDR_BITS-1:0] STRAY_ADDR  = CSR_ADDR_BITS'(4);
   localparam int                       SETTLE_CYC  = ENTRIES + 6;
   localparam int unsigned              CYCLE_LIMIT = 400000;
   localparam int                       PHASES      = 10;
   localparam int                       PHASE_ITEMS = 115;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int                       fail_count;
   int                       results_pending;
   int unsigned              cycle_count = 0;
   bit                       idle_on = 1'b1;

   int unsigned phase_limit [PHASES] = '{16, 2, 31, 1, 7, 0, 16, 3, 20, 12};

   lbc_req_if req_chan ();
   lbc_rsp_if rsp_chan ();

   lru_block_cache_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lbc_cache_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: ready with random stall bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // one request beat, with an optional idle burst ahead of it
   task automatic send_request(input logic act, input logic [KEY_BITS-1:0] key,
                               input logic [WORD_BITS-1:0] word);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= act;
      req_chan.block_number <= key;
      req_chan.fill_data    <= word;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // wait until every predicted result has come back, then let the block go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // apb setup and access phases
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // set the limit (junk in the upper bits) and read it back
   task automatic set_limit(input int unsigned lim);
      csr_access(1'b1, LIMIT_ADDR,
                 CSR_DATA_BITS'({$urandom(), LIMIT_BITS'(lim)} >> LIMIT_BITS << LIMIT_BITS
                                | CSR_DATA_BITS'(lim)));
      csr_access(1'b0, LIMIT_ADDR, '0);
   endtask

   // random traffic over a key pool a little larger than the limit
   task automatic run_phase(input int unsigned lim, input int items, input bit stall);
      logic [KEY_BITS-1:0]  pool [$];
      logic [KEY_BITS-1:0]  key;
      int unsigned          span;
      span = (lim == 0) ? 1 : (lim > ENTRIES) ? ENTRIES : lim;
      repeat (span + $urandom_range(1, 6)) pool.push_back($urandom());
      settle();
      set_limit(lim);
      idle_on = stall;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            key = $urandom();
         end else begin
            key = pool[$urandom_range(0, pool.size() - 1)];
         end
         send_request($urandom_range(0, 1) ? ACT_INSERT : ACT_LOOKUP, key,
                      {$urandom(), $urandom()});
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action       <= ACT_LOOKUP;
      req_chan.block_number <= '0;
      req_chan.fill_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset limit, empty miss, extremes, present-block insert
      csr_access(1'b0, LIMIT_ADDR, '0);
      send_request(ACT_LOOKUP, '0, '1);
      send_request(ACT_INSERT, '0, '0);
      send_request(ACT_INSERT, '1, '1);
      send_request(ACT_INSERT, 32'h8000_0001, 64'h8000_0000_0000_0001);
      send_request(ACT_LOOKUP, '1, '0);
      send_request(ACT_LOOKUP, '0, '1);
      send_request(ACT_INSERT, '0, 64'h0123_4567_89ab_cdef);
      send_request(ACT_LOOKUP, '0, '0);
      send_request(ACT_LOOKUP, 32'h7fff_fffe, '0);

      // limit of three with three lines filled: evictions start
      settle();
      set_limit(3);
      send_request(ACT_INSERT, 32'h0000_1234, 64'h5555_aaaa_5555_aaaa);
      send_request(ACT_INSERT, '1, 64'haaaa_5555_aaaa_5555);
      send_request(ACT_LOOKUP, '0, '0);
      send_request(ACT_INSERT, '0, 64'hffff_0000_ffff_0000);
      send_request(ACT_INSERT, 32'h0000_1234, 64'h0f0f_0f0f_0f0f_0f0f);

      // limit zero acts as one, and sits below the fill
      settle();
      set_limit(0);
      send_request(ACT_INSERT, 32'h00ff_00ff, 64'hf0f0_f0f0_f0f0_f0f0);
      send_request(ACT_INSERT, 32'h00ff_00ff, 64'h1111_2222_3333_4444);
      send_request(ACT_LOOKUP, 32'h00ff_00ff, '0);

      // write past the register list is dropped; largest limit acts as full size
      settle();
      csr_access(1'b1, STRAY_ADDR, 32'd2);
      csr_access(1'b0, LIMIT_ADDR, '0);
      set_limit(31);
      send_request(ACT_INSERT, 32'hcafe_f00d, 64'h7fff_ffff_ffff_ffff);
      send_request(ACT_LOOKUP, 32'hcafe_f00d, '0);
      send_request(ACT_LOOKUP, 32'h1357_9bdf, '0);

      // random phases over several limits; every third one and the last run without idling
      for (int p = 0; p < PHASES; p++) begin
         run_phase(phase_limit[p], PHASE_ITEMS, (p < PHASES - 1) && (p % 3 != 2));
      end
      idle_on = 1'b0;
      settle();

      if (fail_count == 0 && results_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/lbc_pkg.sv
sv/lbc_if.sv
sv/lbc_ram.sv
sv/lbc_csr.sv
sv/lbc_engine.sv
sv/lru_block_cache_core.sv
tb/lbc_cache_checker.sv
tb/lru_block_cache_core_tb.sv
